>>> hw/rtl/mmn_pkg.sv
// ============================================================================
// mmn_pkg
// Shared types and constants for the min-max normalizer: the command and
// status bundles between controller and datapath, and the quotient format.
// ============================================================================
package mmn_pkg;

    // The quotient is one output byte, produced one bit per divider step.
    localparam int unsigned QUOT_BITS = 8;
    localparam int unsigned CNT_BITS  = $clog2(QUOT_BITS);

    // Index of the last divider step.
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(QUOT_BITS - 1);

    // Largest output code, given for samples at or above the maximum.
    localparam logic [QUOT_BITS-1:0] FULL_SCALE = {QUOT_BITS{1'b1}};

    // Input mode codes.
    localparam logic MODE_OBSERVE   = 1'b0;
    localparam logic MODE_NORMALIZE = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic observe;   // fold the incoming sample into min and max
        logic capture;   // hold the incoming sample for normalizing
        logic prep;      // classify the sample and set up the divider
        logic div_step;  // one restoring division step
        logic load_out;  // move the finished result into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fast;      // result known without dividing
    } t_dp_status;

endpackage

>>> hw/rtl/mmn_if.sv
// ============================================================================
// mmn_if
// Valid/ready request channels of the min-max normalizer: the sample input
// channel and the normalized result channel.
// ============================================================================
interface mmn_in_if #(
    parameter int unsigned SAMPLE_BITS = 16
);
    logic                   valid;
    logic                   ready;
    logic                   mode;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output mode, output sample, input ready);
    modport sink   (input valid, input mode, input sample, output ready);
endinterface

interface mmn_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] normalized_value;
    logic       degenerate_range;

    modport source (output valid, output normalized_value, output degenerate_range,
                    input ready);
    modport sink   (input valid, input normalized_value, input degenerate_range,
                    output ready);
endinterface

>>> hw/rtl/min_max_normalizer.sv
// An observe request is absorbed in the cycle it is accepted. A normalize
// request is captured, then passes the setup state, the 8-step radix-2
// divider unless the result is known without dividing (degenerate range or
// saturation), and the done state that loads the output register. Observe
// requests are taken every cycle while no normalize is in flight.
// Reset (synchronous, active low) sets max to 0, min to all ones, idle state.
// ============================================================================
// min_max_normalizer
// Maps gradient-magnitude samples onto 0..255 using a running minimum and
// maximum gathered by observe requests.
// ============================================================================
module min_max_normalizer #(
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mmn_in_if.sink        i_in,
    mmn_out_if.source     o_out
);

    // Commands and status between the sequencer and the datapath.
    mmn_pkg::t_dp_cmd     cmd;
    mmn_pkg::t_dp_status  status;

    logic [mmn_pkg::QUOT_BITS-1:0] value;
    logic                          degen;

    // The controller accepts requests only when idle. An observe request
    // updates min and max at once; a normalize request is captured, set up,
    // taken through eight quotient steps unless its result is known without
    // dividing, and handed off into the output register. A finished result
    // may wait in that register while new requests are already being taken.
    mmn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_mode   (i_in.mode),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    // The datapath scales (sample - min) by 255 and divides by (max - min)
    // with a restoring divider. Since the sample lies strictly between min
    // and max on that path, the quotient always fits in one byte.
    mmn_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_status (status),
        .i_sample (SAMPLE_BITS'(i_in.sample)),
        .o_value  (value),
        .o_degen  (degen)
    );

    assign o_out.normalized_value = value;
    assign o_out.degenerate_range = degen;

endmodule

>>> hw/rtl/mmn_ctrl.sv
// ============================================================================
// mmn_ctrl
// Controller of the min-max normalizer: sequences a normalize request through
// setup and, when dividing, eight division steps; owns the output valid flag.
// ============================================================================
module mmn_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_mode,
    output logic                o_in_ready,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output mmn_pkg::t_dp_cmd    o_cmd,
    input  mmn_pkg::t_dp_status i_status
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PREP = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state                         r_state, n_state;
    logic [mmn_pkg::CNT_BITS-1:0]   r_cnt, n_cnt;
    logic                           r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_ready  = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_mode == mmn_pkg::MODE_NORMALIZE) begin
                        o_cmd.capture = 1'b1;
                        n_state       = S_PREP;
                    end else begin
                        o_cmd.observe = 1'b1;
                    end
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_cnt      = '0;
                n_state    = i_status.fast ? S_DONE : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == mmn_pkg::CNT_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Wait until the output register is free or being drained.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> hw/rtl/mmn_datapath.sv
// ============================================================================
// mmn_datapath
// Datapath of the min-max normalizer: running min and max, sample scaling by
// 255, a radix-2 restoring divider and the output result register.
// ============================================================================
module mmn_datapath #(
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  mmn_pkg::t_dp_cmd         i_cmd,
    output mmn_pkg::t_dp_status      o_status,
    input  logic [SAMPLE_BITS-1:0]   i_sample,
    output logic [mmn_pkg::QUOT_BITS-1:0] o_value,
    output logic                     o_degen
);

    localparam int unsigned QB = mmn_pkg::QUOT_BITS;
    localparam int unsigned NB = SAMPLE_BITS + QB;

    logic [SAMPLE_BITS-1:0] r_max, r_min, r_sample, r_span, r_rem;
    logic [QB-1:0]          r_num_lo, r_quot, r_out_value;
    logic                   r_degen, r_out_degen;

    logic                   degen, at_low, at_high;
    logic [SAMPLE_BITS-1:0] diff;
    logic [NB-1:0]          num;
    logic [SAMPLE_BITS:0]   trial;
    logic [SAMPLE_BITS:0]   trial_sub;
    logic                   q_bit;

    assign degen   = (r_max <= r_min);
    assign at_low  = (r_sample <= r_min);
    assign at_high = (r_sample >= r_max);
    assign o_status.fast = degen || at_low || at_high;

    // (sample - min) * 255 as (d << 8) - d.
    assign diff = r_sample - r_min;
    assign num  = {diff, {QB{1'b0}}} - NB'(diff);

    // The partial remainder stays below the span, so one extra bit suffices.
    assign trial     = {r_rem, r_num_lo[QB-1]};
    assign q_bit     = (trial >= {1'b0, r_span});
    assign trial_sub = trial - {1'b0, r_span};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= '0;
            r_min <= '1;
        end else if (i_cmd.observe) begin
            if (i_sample > r_max) begin
                r_max <= i_sample;
            end
            if (i_sample < r_min) begin
                r_min <= i_sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sample <= i_sample;
        end
        if (i_cmd.prep) begin
            r_span   <= r_max - r_min;
            r_rem    <= num[NB-1:QB];
            r_num_lo <= num[QB-1:0];
            r_degen  <= degen;
            if (!degen && !at_low && at_high) begin
                r_quot <= mmn_pkg::FULL_SCALE;
            end else begin
                r_quot <= '0;
            end
        end
        if (i_cmd.div_step) begin
            r_rem    <= q_bit ? trial_sub[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
            r_num_lo <= {r_num_lo[QB-2:0], 1'b0};
            r_quot   <= {r_quot[QB-2:0], q_bit};
        end
        if (i_cmd.load_out) begin
            r_out_value <= r_quot;
            r_out_degen <= r_degen;
        end
    end

    assign o_value = r_out_value;
    assign o_degen = r_out_degen;

endmodule

>>> verif/tb.sv
// ============================================================================
// tb
// Self-checking testbench for min_max_normalizer. Observe requests widen a
// running minimum and maximum; normalize requests return a scaled byte. A
// directed table comes first, then a long random run in which the observed
// range grows slowly toward the full sample range. Random idling runs on
// both channels, with one long hold-off on the result side and one drain
// pause on the request side. Every result is compared, field by field, with
// an independent prediction.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned     SAMPLE_BITS      = 16;
    localparam int unsigned     RAND_REQUESTS    = 1230;
    // The last requests of the run go out with no idling on either side.
    localparam int unsigned     CALM_TAIL        = 150;
    localparam int unsigned     HOLD_OFF_AT      = 300;
    localparam int unsigned     DRAIN_AT         = 700;
    localparam int unsigned     LONG_HOLD_CYCLES = 300;
    // Settling time after the last owed result, to catch any late stray result.
    localparam int unsigned     SETTLE_CYCLES    = 40;
    localparam int unsigned     MAX_REPORTS      = 100;
    localparam longint unsigned RUN_LIMIT_NS     = 3_000_000;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_TOP = '1;

    // One normalize result: the scaled byte and the degenerate-range flag.
    typedef struct packed {
        logic [7:0] value;
        logic       degenerate;
    } t_norm_result;

    // One row of the directed table. Rows with typed set carry their
    // expected result; the others are predicted.
    typedef struct packed {
        logic                   mode;
        logic [SAMPLE_BITS-1:0] sample;
        logic                   typed;
        logic [7:0]             value;
        logic                   degenerate;
    } t_directed_row;

    localparam int unsigned N_DIRECTED = 23;

    t_directed_row directed_rows [N_DIRECTED] = '{
        // Nothing observed yet: max 0 is below min all ones, so degenerate.
        '{mmn_pkg::MODE_NORMALIZE, 16'd0,     1'b1, 8'd0,                1'b1},
        '{mmn_pkg::MODE_NORMALIZE, 16'hFFFF,  1'b1, 8'd0,                1'b1},
        // A single observed value gives max equal to min, still degenerate.
        '{mmn_pkg::MODE_OBSERVE,   16'd1000,  1'b0, 8'd0,                1'b0},
        '{mmn_pkg::MODE_NORMALIZE, 16'd1000,  1'b1, 8'd0,                1'b1},
        '{mmn_pkg::MODE_NORMALIZE, 16'd0,     1'b1, 8'd0,                1'b1},
        // Range 1000..3000: the ends and beyond saturate.
        '{mmn_pkg::MODE_OBSERVE,   16'd3000,  1'b0, 8'd0,                1'b0},
        '{mmn_pkg::MODE_NORMALIZE, 16'd1000,  1'b1, 8'd0,                1'b0},
        '{mmn_pkg::MODE_NORMALIZE, 16'd3000,  1'b1, mmn_pkg::FULL_SCALE, 1'b0},
        '{mmn_pkg::MODE_NORMALIZE, 16'd0,     1'b1, 8'd0,                1'b0},
        '{mmn_pkg::MODE_NORMALIZE, 16'hFFFF,  1'b1, mmn_pkg::FULL_SCALE, 1'b0},
        '{mmn_pkg::MODE_NORMALIZE, 16'd999,   1'b1, 8'd0,                1'b0},
        '{mmn_pkg::MODE_NORMALIZE, 16'd3001,  1'b1, mmn_pkg::FULL_SCALE, 1'b0},
        // Interior points go through the divider.
        '{mmn_pkg::MODE_NORMALIZE, 16'd2000,  1'b0, 8'd0,                1'b0},
        '{mmn_pkg::MODE_NORMALIZE, 16'd1001,  1'b0, 8'd0,                1'b0},
        '{mmn_pkg::MODE_NORMALIZE, 16'd2999,  1'b0, 8'd0,                1'b0},
        // An observe inside the range leaves it alone.
        '{mmn_pkg::MODE_OBSERVE,   16'd2000,  1'b0, 8'd0,                1'b0},
        '{mmn_pkg::MODE_NORMALIZE, 16'd1500,  1'b0, 8'd0,                1'b0},
        '{mmn_pkg::MODE_OBSERVE,   16'd998,   1'b0, 8'd0,                1'b0},
        '{mmn_pkg::MODE_NORMALIZE, 16'h5555,  1'b1, mmn_pkg::FULL_SCALE, 1'b0},
        '{mmn_pkg::MODE_NORMALIZE, 16'hAAAA,  1'b1, mmn_pkg::FULL_SCALE, 1'b0},
        '{mmn_pkg::MODE_NORMALIZE, 16'd999,   1'b0, 8'd0,                1'b0},
        '{mmn_pkg::MODE_OBSERVE,   16'd3100,  1'b0, 8'd0,                1'b0},
        '{mmn_pkg::MODE_NORMALIZE, 16'd3050,  1'b0, 8'd0,                1'b0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    mmn_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
    mmn_out_if                             out_ch ();

    min_max_normalizer #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // Our own copy of the running range, as the block should hold it.
    logic [SAMPLE_BITS-1:0] seen_min = '1;
    logic [SAMPLE_BITS-1:0] seen_max = '0;

    // Normalize results still owed by the block, oldest first.
    t_norm_result pending_norms [$];

    int unsigned mismatch_count   = 0;
    // Shared between the request and result sides: whether random idling is
    // allowed right now, and a one-shot ask for a long result hold-off.
    bit          idle_enabled     = 1'b0;
    bit          hold_off_pending = 1'b0;

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // Append one expected result to the owed list.
    function automatic void owe_result(input t_norm_result r);
        pending_norms = {pending_norms, r};
    endfunction

    // An observe request folds the sample into the running range.
    function automatic void widen_range(input logic [SAMPLE_BITS-1:0] s);
        if (s > seen_max)
            seen_max = s;
        if (s < seen_min)
            seen_min = s;
    endfunction

    // What a normalize request should return for the current range. The
    // degenerate check comes first, then the two saturating ends, and only
    // strictly interior samples are divided.
    function automatic t_norm_result scale_sample(input logic [SAMPLE_BITS-1:0] s);
        t_norm_result r;
        logic [31:0]  delta;
        logic [31:0]  span;
        r = '0;
        if (seen_max <= seen_min) begin
            r.degenerate = 1'b1;
        end else if (s <= seen_min) begin
            r.value = 8'd0;
        end else if (s >= seen_max) begin
            r.value = mmn_pkg::FULL_SCALE;
        end else begin
            delta   = {16'd0, s} - {16'd0, seen_min};
            span    = {16'd0, seen_max} - {16'd0, seen_min};
            r.value = 8'((delta * 32'(mmn_pkg::FULL_SCALE)) / span);
        end
        return r;
    endfunction

    // Update the predicted range or queue the predicted result of a request
    // the block has just accepted.
    function automatic void account_request(input logic m, input logic [SAMPLE_BITS-1:0] s);
        if (m == mmn_pkg::MODE_OBSERVE)
            widen_range(s);
        else
            owe_result(scale_sample(s));
    endfunction

    // Offer one request and return at the edge where it is accepted. A gap
    // drops valid for that many cycles first; a drain pause additionally
    // holds valid low until every owed result has come back. Valid stays
    // high after acceptance so back-to-back requests need no extra edge.
    task automatic offer_request(input logic m, input logic [SAMPLE_BITS-1:0] s,
                                 input int unsigned gap, input bit drain);
        if (gap != 0 || drain) begin
            in_ch.valid <= 1'b0;
            repeat ((gap == 0) ? 1 : gap) @(posedge i_clk);
            while (drain && pending_norms.size() != 0)
                @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.mode   <= m;
        in_ch.sample <= s;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Request side: reset, directed table, random run, end of test.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic                   m;
        logic [SAMPLE_BITS-1:0] s;
        int unsigned            gap;
        int unsigned            pick;
        int unsigned            stride;
        bit                     drain;

        i_rst_n      <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.mode   <= mmn_pkg::MODE_OBSERVE;
        in_ch.sample <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table, back to back. Typed rows queue their own expected
        // result; observe rows still update our copy of the range.
        for (int unsigned i = 0; i < N_DIRECTED; i++) begin
            offer_request(directed_rows[i].mode, directed_rows[i].sample, 0, 1'b0);
            if (directed_rows[i].mode == mmn_pkg::MODE_NORMALIZE && directed_rows[i].typed)
                owe_result(t_norm_result'{directed_rows[i].value,
                                          directed_rows[i].degenerate});
            else
                account_request(directed_rows[i].mode, directed_rows[i].sample);
        end

        // Random run. Observes mostly land inside the range or nudge it out a
        // little, so the range grows slowly and normalizes keep hitting the
        // divider over many different spans. Near the end the full-scale
        // extremes get observed as well.
        for (int unsigned n = 0; n < RAND_REQUESTS; n++) begin
            // Idling comes in stretches: three hundred-request blocks with it,
            // then one without, and none at all in the calm tail.
            idle_enabled = (n < RAND_REQUESTS - CALM_TAIL) && ((n / 100) % 4 != 3);
            if (n == HOLD_OFF_AT)
                hold_off_pending = 1'b1;
            drain = (n == DRAIN_AT);

            m    = ($urandom_range(0, 99) < 20) ? mmn_pkg::MODE_OBSERVE
                                                : mmn_pkg::MODE_NORMALIZE;
            pick = $urandom_range(0, 99);
            if (m == mmn_pkg::MODE_OBSERVE) begin
                if (n >= RAND_REQUESTS * 4 / 5 && pick < 4) begin
                    s = pick[0] ? SAMPLE_TOP : '0;
                end else if (pick < 55) begin
                    s = SAMPLE_BITS'($urandom_range(seen_min, seen_max));
                end else if (pick < 78) begin
                    stride = $urandom_range(1, 200);
                    s = (seen_min > stride) ? seen_min - SAMPLE_BITS'(stride) : '0;
                end else begin
                    stride = $urandom_range(1, 200);
                    s = (SAMPLE_TOP - seen_max > stride) ?
                        seen_max + SAMPLE_BITS'(stride) : SAMPLE_TOP;
                end
            end else begin
                if (pick < 50) begin
                    s = SAMPLE_BITS'($urandom_range(seen_min, seen_max));
                end else if (pick < 66) begin
                    // The boundaries and their nearest neighbors.
                    case (pick % 4)
                        0: s = seen_min;
                        1: s = seen_min + 1'b1;
                        2: s = seen_max;
                        default: s = seen_max - 1'b1;
                    endcase
                end else if (pick < 76) begin
                    s = SAMPLE_BITS'($urandom_range(0, seen_min));
                end else if (pick < 86) begin
                    s = SAMPLE_BITS'($urandom_range(seen_max, SAMPLE_TOP));
                end else begin
                    s = SAMPLE_BITS'($urandom);
                end
            end

            gap = (idle_enabled && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
            offer_request(m, s, gap, drain);
            account_request(m, s);
        end

        in_ch.valid <= 1'b0;
        while (pending_norms.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: ready with random stalls, and once a long hold-off while
    // requests keep coming, so the block fills and back-pressures its input.
    // ------------------------------------------------------------------------
    initial begin : result_ready
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
            end else if (idle_enabled && $urandom_range(0, 7) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Compare each accepted result with the oldest owed prediction.
    always @(posedge i_clk) begin : result_check
        t_norm_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_norms.size() == 0) begin
                flag_mismatch($sformatf("unexpected result value %0d degenerate %0b",
                                        out_ch.normalized_value, out_ch.degenerate_range));
            end else begin
                want = pending_norms.pop_front();
                if (out_ch.normalized_value !== want.value)
                    flag_mismatch($sformatf("normalized_value %0d, expected %0d",
                                            out_ch.normalized_value, want.value));
                if (out_ch.degenerate_range !== want.degenerate)
                    flag_mismatch($sformatf("degenerate_range %0b, expected %0b",
                                            out_ch.degenerate_range, want.degenerate));
            end
        end
    end

    // Hard stop in case a handshake never completes.
    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
